/* design/ucam_pkg.sv */
// ----------------------------------------------------------------------------
// UTF-8 case and accent mapper: shared package
// Types, register indexes, mode codes and the accented Latin pair table.
// ----------------------------------------------------------------------------
package ucam_pkg;

  // Width of the room counter; capacity is clamped to what it can hold.
  localparam int ROOM_BITS = 16;
  localparam int CAP_BITS  = 16;
  localparam int CAP_W     = (ROOM_BITS > CAP_BITS) ? ROOM_BITS : CAP_BITS;
  localparam logic [ROOM_BITS-1:0] ROOM_MAX = '1;

  localparam int NUM_PAIRS = 38;

  // Configuration register indexes.
  localparam logic REG_MODE     = 1'b0;
  localparam logic REG_CAPACITY = 1'b1;

  // Mode codes; any code from MODE_STRIP upwards strips accents.
  localparam logic [1:0] MODE_LOWER = 2'd0;
  localparam logic [1:0] MODE_UPPER = 2'd1;
  localparam logic [1:0] MODE_STRIP = 2'd2;

  localparam logic [7:0] CHAR_UA = 8'h41;  // 'A'
  localparam logic [7:0] CHAR_UZ = 8'h5A;  // 'Z'
  localparam logic [7:0] CHAR_LA = 8'h61;  // 'a'
  localparam logic [7:0] CHAR_LZ = 8'h7A;  // 'z'
  localparam logic [7:0] CASE_OFS = 8'h20;

  // One entry of the queue between front and back: one or two bytes.
  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic       two;
    logic       last;
  } ent_t;

  typedef struct packed {
    logic        hit_up;
    logic        hit_lo;
    logic [15:0] up_enc;
    logic [15:0] lo_enc;
    logic [7:0]  base;
  } look_t;

  localparam logic [8:0] UP_CP [NUM_PAIRS] = '{
    9'h100, 9'h0C1, 9'h1CD, 9'h0C0, 9'h0C2, 9'h0C4, 9'h0C3,
    9'h112, 9'h0C9, 9'h11A, 9'h0C8, 9'h0CA, 9'h0CB,
    9'h12A, 9'h0CD, 9'h1CF, 9'h0CC, 9'h0CE, 9'h0CF,
    9'h14C, 9'h0D3, 9'h1D1, 9'h0D2, 9'h0D4, 9'h0D6, 9'h0D5,
    9'h16A, 9'h0DA, 9'h1D3, 9'h0D9, 9'h0DB, 9'h0DC, 9'h1D5, 9'h1D7,
    9'h1D9, 9'h1DB,
    9'h0D1,
    9'h0C7
  };

  localparam logic [8:0] LO_CP [NUM_PAIRS] = '{
    9'h101, 9'h0E1, 9'h1CE, 9'h0E0, 9'h0E2, 9'h0E4, 9'h0E3,
    9'h113, 9'h0E9, 9'h11B, 9'h0E8, 9'h0EA, 9'h0EB,
    9'h12B, 9'h0ED, 9'h1D0, 9'h0EC, 9'h0EE, 9'h0EF,
    9'h14D, 9'h0F3, 9'h1D2, 9'h0F2, 9'h0F4, 9'h0F6, 9'h0F5,
    9'h16B, 9'h0FA, 9'h1D4, 9'h0F9, 9'h0FB, 9'h0FC, 9'h1D6, 9'h1D8,
    9'h1DA, 9'h1DC,
    9'h0F1,
    9'h0E7
  };

  localparam logic [7:0] BASE_CH [NUM_PAIRS] = '{
    8'h41, 8'h41, 8'h41, 8'h41, 8'h41, 8'h41, 8'h41,
    8'h45, 8'h45, 8'h45, 8'h45, 8'h45, 8'h45,
    8'h49, 8'h49, 8'h49, 8'h49, 8'h49, 8'h49,
    8'h4F, 8'h4F, 8'h4F, 8'h4F, 8'h4F, 8'h4F, 8'h4F,
    8'h55, 8'h55, 8'h55, 8'h55, 8'h55, 8'h55, 8'h55, 8'h55,
    8'h55, 8'h55,
    8'h4E,
    8'h43
  };

  // Two-byte UTF-8 encoding of a code point, lead byte in the upper half.
  function automatic logic [15:0] enc2(input logic [8:0] cp);
    enc2 = {3'b110, 2'b00, cp[8:6], 2'b10, cp[5:0]};
  endfunction

  // Character length from its lead byte; stray continuation bytes count one.
  function automatic logic [2:0] char_len(input logic [7:0] b);
    if (b < 8'hC0)      char_len = 3'd1;
    else if (b < 8'hE0) char_len = 3'd2;
    else if (b < 8'hF0) char_len = 3'd3;
    else if (b < 8'hF8) char_len = 3'd4;
    else if (b < 8'hFC) char_len = 3'd5;
    else                char_len = 3'd6;
  endfunction

  // Exact match of a byte pair against both columns of the table.
  function automatic look_t pair_lookup(input logic [15:0] key);
    look_t r;
    r = '0;
    for (int i = 0; i < NUM_PAIRS; i++) begin
      if (!(r.hit_up || r.hit_lo) &&
          (key == enc2(UP_CP[i]) || key == enc2(LO_CP[i]))) begin
        r.hit_up = (key == enc2(UP_CP[i]));
        r.hit_lo = (key == enc2(LO_CP[i]));
        r.up_enc = enc2(UP_CP[i]);
        r.lo_enc = enc2(LO_CP[i]);
        r.base   = BASE_CH[i];
      end
    end
    return r;
  endfunction

  // Room counter load value from a capacity write, clamped to the counter.
  function automatic logic [ROOM_BITS-1:0] room_load(input logic [CAP_BITS-1:0] cap);
    logic [CAP_W-1:0] c;
    c = CAP_W'(cap);
    if (c > CAP_W'(ROOM_MAX)) room_load = ROOM_MAX;
    else                      room_load = ROOM_BITS'(c);
  endfunction

  // Saturating subtract of a small count.
  function automatic logic [ROOM_BITS-1:0] room_sub(input logic [ROOM_BITS-1:0] r,
                                                    input logic [2:0] k);
    if (r > ROOM_BITS'(k)) room_sub = r - ROOM_BITS'(k);
    else                   room_sub = '0;
  endfunction

endpackage

/* design/ucam_front.sv */
// ----------------------------------------------------------------------------
// UTF-8 case and accent mapper: front end
// Accepts bytes, tracks characters and room, maps them and pushes entries.
// ----------------------------------------------------------------------------
module ucam_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_index_i,
  input  logic [15:0]          cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           in_byte_i,
  input  logic                 q_full_i,
  output logic                 push_o,
  output ucam_pkg::ent_t       push_ent_o
);
  import ucam_pkg::*;

  logic [1:0]           mode_q, mode_d;
  logic [CAP_BITS-1:0]  cap_q, cap_d;
  logic [ROOM_BITS-1:0] room_q, room_d;
  logic [7:0]           held_q, held_d;
  logic [2:0]           left_q, left_d;
  logic                 two_q, two_d;
  logic                 stop_q, stop_d;

  logic                 accept;
  logic                 strip;
  logic [2:0]           len;
  look_t                look;
  logic [7:0]           b;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign strip      = (mode_q >= MODE_STRIP);
  assign len        = char_len(in_byte_i);
  assign look       = pair_lookup({held_q, in_byte_i});

  always_comb begin
    mode_d     = mode_q;
    cap_d      = cap_q;
    room_d     = room_q;
    held_d     = held_q;
    left_d     = left_q;
    two_d      = two_q;
    stop_d     = stop_q;
    push_o     = 1'b0;
    push_ent_o = '0;
    b          = in_byte_i;

    if (accept) begin
      priority if (in_byte_i == 8'h00) begin
        // End of string: terminator, and a fresh count for the next string.
        push_o          = 1'b1;
        push_ent_o.last = 1'b1;
        held_d          = '0;
        left_d          = '0;
        two_d           = 1'b0;
        stop_d          = 1'b0;
        room_d          = room_load(cap_q);
      end else if (left_q != 3'd0) begin
        push_o = 1'b1;
        if (two_q) begin
          if (mode_q == MODE_LOWER && look.hit_up) begin
            push_ent_o.two = 1'b1;
            push_ent_o.b0  = look.lo_enc[15:8];
            push_ent_o.b1  = look.lo_enc[7:0];
          end else if (mode_q == MODE_UPPER && look.hit_lo) begin
            push_ent_o.two = 1'b1;
            push_ent_o.b0  = look.up_enc[15:8];
            push_ent_o.b1  = look.up_enc[7:0];
          end else if (strip && (look.hit_up || look.hit_lo)) begin
            push_ent_o.b0 = look.hit_up ? look.base : look.base + CASE_OFS;
            room_d        = room_sub(room_q, 3'd1);
          end else begin
            push_ent_o.two = 1'b1;
            push_ent_o.b0  = held_q;
            push_ent_o.b1  = in_byte_i;
            if (strip) room_d = room_sub(room_q, 3'd2);
          end
          two_d  = 1'b0;
          held_d = '0;
          left_d = '0;
        end else begin
          push_ent_o.b0 = in_byte_i;
          left_d        = left_q - 3'd1;
        end
      end else if (stop_q) begin
        // Room ran out earlier in this string: skip the byte.
      end else if (!strip && ({1'b0, room_q} < (ROOM_BITS+1)'(len) + 1'b1)) begin
        stop_d = 1'b1;
      end else if (strip && room_q == '0) begin
        stop_d = 1'b1;
      end else begin
        if (!strip)             room_d = room_q - ROOM_BITS'(len);
        else if (len != 3'd2)   room_d = room_sub(room_q, len);
        if (len == 3'd1) begin
          if (mode_q == MODE_LOWER && b >= CHAR_UA && b <= CHAR_UZ)
            b = b + CASE_OFS;
          else if (mode_q == MODE_UPPER && b >= CHAR_LA && b <= CHAR_LZ)
            b = b - CASE_OFS;
          push_o        = 1'b1;
          push_ent_o.b0 = b;
        end else if (len == 3'd2) begin
          held_d = in_byte_i;
          two_d  = 1'b1;
          left_d = 3'd1;
        end else begin
          push_o        = 1'b1;
          push_ent_o.b0 = in_byte_i;
          two_d         = 1'b0;
          left_d        = len - 3'd1;
        end
      end
    end

    if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_MODE: mode_d = cfg_data_i[1:0];
        REG_CAPACITY: begin
          cap_d  = cfg_data_i;
          room_d = room_load(cfg_data_i);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_LOWER;
      cap_q  <= '1;
      room_q <= room_load('1);
      held_q <= '0;
      left_q <= '0;
      two_q  <= 1'b0;
      stop_q <= 1'b0;
    end else begin
      mode_q <= mode_d;
      cap_q  <= cap_d;
      room_q <= room_d;
      held_q <= held_d;
      left_q <= left_d;
      two_q  <= two_d;
      stop_q <= stop_d;
    end
  end

  a_held_one_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    two_q |-> left_q == 3'd1)
    else $error("held lead without exactly one byte due");

  a_term_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_byte_i == 8'h00 && !cfg_we_i) |=> (!stop_q && !two_q && left_q == 3'd0))
    else $error("terminator left character state behind");

endmodule

/* design/ucam_queue.sv */
// ----------------------------------------------------------------------------
// UTF-8 case and accent mapper: entry queue
// Two-entry queue that decouples the front end from the output stage.
// ----------------------------------------------------------------------------
module ucam_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ucam_pkg::ent_t push_ent_i,
  output logic           full_o,
  output logic           valid_o,
  output ucam_pkg::ent_t ent_o,
  input  logic           pop_i
);
  import ucam_pkg::*;

  ent_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign ent_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_ent_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= !wr_q;
      if (pop_i)  rd_q <= !rd_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("pop from empty queue");

endmodule

/* design/ucam_back.sv */
// ----------------------------------------------------------------------------
// UTF-8 case and accent mapper: output stage
// Takes queue entries and sends their one or two bytes as output beats.
// ----------------------------------------------------------------------------
module ucam_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  input  ucam_pkg::ent_t q_ent_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [7:0]     out_byte_o,
  output logic           last_o
);
  import ucam_pkg::*;

  logic valid_q, valid_d;
  logic sec_q, sec_d;
  ent_t ent_q, ent_d;
  logic beat_done, ent_done, load;

  assign beat_done = valid_q && out_ready_i;
  assign ent_done  = beat_done && (!ent_q.two || sec_q);
  assign load      = !valid_q || ent_done;
  assign pop_o     = load && q_valid_i;

  assign out_valid_o = valid_q;
  assign out_byte_o  = sec_q ? ent_q.b1 : ent_q.b0;
  assign last_o      = ent_q.last;

  always_comb begin
    valid_d = valid_q;
    sec_d   = sec_q;
    ent_d   = ent_q;
    if (load) begin
      valid_d = q_valid_i;
      ent_d   = q_ent_i;
      sec_d   = 1'b0;
    end else if (beat_done) begin
      sec_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sec_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      sec_q   <= sec_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  a_sec_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sec_q |-> (valid_q && ent_q.two))
    else $error("second byte shown for a one-byte entry");

  a_last_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_o) |-> (out_byte_o == 8'h00 && !ent_q.two))
    else $error("terminator beat carries a nonzero byte");

endmodule

/* design/utf8_case_accent_mapper.sv */
// ----------------------------------------------------------------------------
// UTF-8 case and accent mapper: top level
// Lower-case, upper-case or accent-stripping filter for a UTF-8 byte stream.
// ----------------------------------------------------------------------------
// The block takes one byte per beat and, at full speed, accepts a byte in
// every cycle that the queue is not full. A one-byte character is written
// into the queue and then loaded into the output stage register, which
// drives its beat. A two-byte lead gives nothing; the following byte gives
// one or two beats, and the output stage sends them one per cycle while the
// receiver is ready. The front end holds all character and room state and
// does the table look-up in the cycle that a byte is taken; a two-entry
// queue lets it run on while the output stage waits for the receiver. A zero
// byte always gives a zero beat with last set and reloads the room count
// from the capacity register. Configuration writes take effect at the next
// clock edge; a capacity write also restarts the room count.
// ----------------------------------------------------------------------------
module utf8_case_accent_mapper (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration: index 0 is the mode, index 1 the capacity.
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // Input bytes.
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  // Output bytes.
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        last_o
);
  import ucam_pkg::*;

  logic push, q_full, q_valid, pop;
  ent_t push_ent, q_ent;

  // Front end: character tracking, room rules and mapping.
  ucam_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_byte_i   (in_byte_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_ent_o  (push_ent)
  );

  // Queue between the two halves.
  ucam_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_ent_i (push_ent),
    .full_o     (q_full),
    .valid_o    (q_valid),
    .ent_o      (q_ent),
    .pop_i      (pop)
  );

  // Output stage: one beat per cycle while the receiver is ready.
  ucam_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_ent_i     (q_ent),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .last_o      (last_o)
  );

endmodule

/* verif/ucam_tb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 case and accent mapper: testbench package
// Expected-beat predictor and scoreboard for the mapper, with its own copy of
// the accented Latin pair table.
// ----------------------------------------------------------------------------
package ucam_tb_pkg;

  import ucam_pkg::*;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } out_beat_t;

  localparam int ACCENT_PAIRS = 38;
  localparam logic [7:0] CASE_GAP = 8'h20;

  // Capital and small code points of each pair, and the letter it strips to.
  localparam logic [8:0] CAPITAL_CP [ACCENT_PAIRS] = '{
    9'h100, 9'h0C1, 9'h1CD, 9'h0C0, 9'h0C2, 9'h0C4, 9'h0C3,
    9'h112, 9'h0C9, 9'h11A, 9'h0C8, 9'h0CA, 9'h0CB,
    9'h12A, 9'h0CD, 9'h1CF, 9'h0CC, 9'h0CE, 9'h0CF,
    9'h14C, 9'h0D3, 9'h1D1, 9'h0D2, 9'h0D4, 9'h0D6, 9'h0D5,
    9'h16A, 9'h0DA, 9'h1D3, 9'h0D9, 9'h0DB, 9'h0DC, 9'h1D5, 9'h1D7, 9'h1D9, 9'h1DB,
    9'h0D1, 9'h0C7
  };

  localparam logic [8:0] SMALL_CP [ACCENT_PAIRS] = '{
    9'h101, 9'h0E1, 9'h1CE, 9'h0E0, 9'h0E2, 9'h0E4, 9'h0E3,
    9'h113, 9'h0E9, 9'h11B, 9'h0E8, 9'h0EA, 9'h0EB,
    9'h12B, 9'h0ED, 9'h1D0, 9'h0EC, 9'h0EE, 9'h0EF,
    9'h14D, 9'h0F3, 9'h1D2, 9'h0F2, 9'h0F4, 9'h0F6, 9'h0F5,
    9'h16B, 9'h0FA, 9'h1D4, 9'h0F9, 9'h0FB, 9'h0FC, 9'h1D6, 9'h1D8, 9'h1DA, 9'h1DC,
    9'h0F1, 9'h0E7
  };

  localparam logic [7:0] PLAIN_LETTER [ACCENT_PAIRS] = '{
    "A", "A", "A", "A", "A", "A", "A",
    "E", "E", "E", "E", "E", "E",
    "I", "I", "I", "I", "I", "I",
    "O", "O", "O", "O", "O", "O", "O",
    "U", "U", "U", "U", "U", "U", "U", "U", "U", "U",
    "N", "C"
  };

  // Lead byte in the upper half, continuation byte in the lower half.
  function automatic logic [15:0] utf8_pair(input logic [8:0] cp);
    return {8'hC0 | {5'd0, cp[8:6]}, 8'h80 | {2'd0, cp[5:0]}};
  endfunction

  class mapped_text_board;

    logic [1:0]  cur_mode;
    logic [15:0] cur_capacity;
    logic [7:0]  lead_held;
    bit          lead_pending;
    int          tail_bytes;
    longint      room;
    bit          refused;

    out_beat_t   due_beats [$];
    int          mismatches;
    int          beats_checked;
    int          strings_closed;

    function new();
      cur_mode       = MODE_LOWER;
      cur_capacity   = 16'hFFFF;
      lead_held      = '0;
      lead_pending   = 1'b0;
      tail_bytes     = 0;
      refused        = 1'b0;
      room           = room_from_capacity();
      mismatches     = 0;
      beats_checked  = 0;
      strings_closed = 0;
    endfunction

    function longint room_from_capacity();
      longint ceiling;
      ceiling = (longint'(1) << ROOM_BITS) - 1;
      return (longint'(cur_capacity) > ceiling) ? ceiling : longint'(cur_capacity);
    endfunction

    function longint sat_less(input longint r, input longint k);
      return (r > k) ? r - k : 0;
    endfunction

    function int length_of(input logic [7:0] b);
      if (b < 8'hC0) return 1;
      if (b < 8'hE0) return 2;
      if (b < 8'hF0) return 3;
      if (b < 8'hF8) return 4;
      if (b < 8'hFC) return 5;
      return 6;
    endfunction

    function void push(input logic [7:0] v, input logic l);
      due_beats.push_back('{value: v, last: l});
    endfunction

    // A capacity write restarts the room count at once.
    function void set_register(input logic idx, input logic [15:0] data);
      if (idx == REG_MODE) begin
        cur_mode = data[1:0];
      end else begin
        cur_capacity = data;
        room = room_from_capacity();
      end
    endfunction

    // Second byte of a held two-byte character: exact match on the byte pair.
    function void close_pair(input logic [7:0] second);
      logic [15:0] key;
      logic [15:0] cap_form;
      logic [15:0] small_form;
      key = {lead_held, second};
      for (int i = 0; i < ACCENT_PAIRS; i++) begin
        cap_form   = utf8_pair(CAPITAL_CP[i]);
        small_form = utf8_pair(SMALL_CP[i]);
        if (cur_mode == MODE_LOWER && key == cap_form) begin
          push(small_form[15:8], 1'b0);
          push(small_form[7:0], 1'b0);
          return;
        end
        if (cur_mode == MODE_UPPER && key == small_form) begin
          push(cap_form[15:8], 1'b0);
          push(cap_form[7:0], 1'b0);
          return;
        end
        if (cur_mode >= MODE_STRIP && (key == cap_form || key == small_form)) begin
          push((key == cap_form) ? PLAIN_LETTER[i] : PLAIN_LETTER[i] + CASE_GAP, 1'b0);
          room = sat_less(room, 1);
          return;
        end
      end
      push(lead_held, 1'b0);
      push(second, 1'b0);
      if (cur_mode >= MODE_STRIP) room = sat_less(room, 2);
    endfunction

    // Works out the beats that one accepted byte causes. Returns 0 when the
    // byte is skipped because the room has run out.
    function bit take_byte(input logic [7:0] b);
      int         len;
      logic [7:0] ch;
      ch = b;
      if (ch == 8'h00) begin
        push(8'h00, 1'b1);
        lead_held    = '0;
        lead_pending = 1'b0;
        tail_bytes   = 0;
        refused      = 1'b0;
        room         = room_from_capacity();
        return 1'b1;
      end
      if (tail_bytes > 0) begin
        if (lead_pending) begin
          close_pair(ch);
          lead_pending = 1'b0;
          lead_held    = '0;
          tail_bytes   = 0;
        end else begin
          push(ch, 1'b0);
          tail_bytes--;
        end
        return 1'b1;
      end
      if (refused) return 1'b0;

      len = length_of(ch);
      if (cur_mode < MODE_STRIP) begin
        if (longint'(len) + 1 > room) begin
          refused = 1'b1;
          return 1'b1;
        end
        room -= len;
      end else begin
        if (room == 0) begin
          refused = 1'b1;
          return 1'b1;
        end
        if (len != 2) room = sat_less(room, len);
      end

      if (len == 1) begin
        if (cur_mode == MODE_LOWER && ch >= "A" && ch <= "Z") ch = ch + CASE_GAP;
        else if (cur_mode == MODE_UPPER && ch >= "a" && ch <= "z") ch = ch - CASE_GAP;
        push(ch, 1'b0);
      end else if (len == 2) begin
        lead_held    = ch;
        lead_pending = 1'b1;
        tail_bytes   = 1;
      end else begin
        push(ch, 1'b0);
        lead_pending = 1'b0;
        tail_bytes   = len - 1;
      end
      return 1'b1;
    endfunction

    function void match_beat(input logic [7:0] v, input logic l);
      out_beat_t want;
      if (due_beats.size() == 0) begin
        $display("%0t: unexpected beat, expected none, got out_byte %02h last %0b",
                 $time, v, l);
        mismatches++;
        return;
      end
      want = due_beats.pop_front();
      beats_checked++;
      if (v !== want.value) begin
        $display("%0t: out_byte mismatch, expected %02h, got %02h", $time, want.value, v);
        mismatches++;
      end
      if (l !== want.last) begin
        $display("%0t: last mismatch, expected %0b, got %0b", $time, want.last, l);
        mismatches++;
      end
      if (want.last) strings_closed++;
    endfunction

    function int pending();
      return due_beats.size();
    endfunction

    function void report_leftover();
      if (due_beats.size() != 0) begin
        $display("%0t: %0d expected beats never arrived, oldest out_byte %02h last %0b",
                 $time, due_beats.size(), due_beats[0].value, due_beats[0].last);
        mismatches += due_beats.size();
      end
    endfunction

  endclass

endpackage

/* verif/tb_utf8_case_accent_mapper.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 case and accent mapper: testbench top level
// Drives byte strings through the mapper in all modes and at capacities from
// zero to full, random idling on both sides, and checks every beat in order.
// ----------------------------------------------------------------------------
module tb_utf8_case_accent_mapper;

  import ucam_pkg::*;
  import ucam_tb_pkg::*;

  // Mode code three is not named in the package; the block treats it as strip.
  localparam logic [1:0] MODE_STRIP_ALIAS = 2'd3;

  localparam int ITEMS        = 450;
  // Cycles allowed after the last expected beat for anything still in flight,
  // such as a held lead that has not produced a beat yet.
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 300;
  localparam int HOLD_PHASE   = 4;
  // No beat on either side for this long means the block has hung. The longest
  // correct quiet stretch comes from the receiver hold-off.
  localparam int QUIET_LIMIT  = 3000;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_index_i;
  logic [15:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  in_byte_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [7:0]  out_byte_o;
  logic        last_o;

  mapped_text_board board;

  bit idle_on;
  bit long_hold;
  int bytes_counted;
  int settings_used;
  int quiet_cycles;

  utf8_case_accent_mapper dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_byte_i   (in_byte_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .last_o      (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Offers one byte and waits until it is taken. Valid is only dropped for an
  // idle burst or a drain, so back-to-back bytes keep it high throughout.
  task automatic send_byte(input logic [7:0] b);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    void'(board.take_byte(b));
    bytes_counted++;
  endtask

  // Stops offering and waits until every expected beat has come out, then
  // waits out the drain allowance in case a held lead is still inside.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Writes the mode register, then the capacity register. Only called while idle.
  task automatic configure(input logic [1:0] m, input logic [15:0] cap);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_MODE;
    cfg_data_i  <= {14'd0, m};
    @(posedge clk_i);
    board.set_register(REG_MODE, {14'd0, m});
    cfg_index_i <= REG_CAPACITY;
    cfg_data_i  <= cap;
    @(posedge clk_i);
    board.set_register(REG_CAPACITY, cap);
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  // Sends one character picked at random. Most are well formed; the rest are
  // stray continuation bytes, leads completed by an arbitrary byte, and leads
  // cut short by the terminator, in which case the string is over.
  task automatic send_char(output bit ended);
    int          pick;
    int          len;
    int          idx;
    logic [15:0] form;
    logic [7:0]  lead;
    ended = 1'b0;
    pick  = $urandom_range(0, 99);
    if (pick < 35) begin
      send_byte(8'($urandom_range(0, 25)) + (($urandom_range(0, 1) != 0) ? "A" : "a"));
    end else if (pick < 45) begin
      send_byte(8'($urandom_range(1, 8'h7F)));
    end else if (pick < 65) begin
      idx  = $urandom_range(0, ACCENT_PAIRS - 1);
      form = utf8_pair(($urandom_range(0, 1) != 0) ? CAPITAL_CP[idx] : SMALL_CP[idx]);
      send_byte(form[15:8]);
      send_byte(form[7:0]);
    end else if (pick < 72) begin
      send_byte(8'($urandom_range(8'hC0, 8'hDF)));
      send_byte(8'($urandom_range(8'h80, 8'hBF)));
    end else if (pick < 82) begin
      len = $urandom_range(3, 6);
      case (len)
        3:       lead = 8'($urandom_range(8'hE0, 8'hEF));
        4:       lead = 8'($urandom_range(8'hF0, 8'hF7));
        5:       lead = 8'($urandom_range(8'hF8, 8'hFB));
        default: lead = 8'($urandom_range(8'hFC, 8'hFF));
      endcase
      send_byte(lead);
      repeat (len - 1) send_byte(8'($urandom_range(8'h80, 8'hBF)));
    end else if (pick < 88) begin
      send_byte(8'($urandom_range(8'h80, 8'hBF)));
    end else if (pick < 94) begin
      send_byte(8'($urandom_range(8'hC0, 8'hDF)));
      send_byte(8'($urandom_range(1, 8'hFF)));
    end else begin
      send_byte(8'($urandom_range(8'hC0, 8'hFF)));
      send_byte(8'h00);
      ended = 1'b1;
    end
  endtask

  // A string of random characters, closed by a zero byte if asked. An open
  // string lets the next register write land in the middle of a string.
  task automatic send_text(input int chars, input bit close);
    bit ended;
    for (int i = 0; i < chars; i++) begin
      send_char(ended);
      if (ended) return;
    end
    if (close) send_byte(8'h00);
  endtask

  // Receiver: random ready bursts, plus one long hold-off on request while the
  // sender keeps offering, so that the internal queue fills and input stalls.
  initial begin
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (long_hold) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        long_hold = 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
  end

  // Every output beat is checked against the oldest expected one.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) board.match_beat(out_byte_o, last_o);
  end

  // Watchdog: ends the run if no beat moves on either side for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, quiet_cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    logic [7:0]  seq [$];
    logic [1:0]  mode_pick;
    logic [15:0] cap_pick;
    int          phase;

    board         = new();
    idle_on       = 1'b1;
    long_hold     = 1'b0;
    bytes_counted = 0;
    settings_used = 0;
    quiet_cycles  = 0;
    phase         = 0;

    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_index_i <= REG_MODE;
    cfg_data_i  <= '0;
    in_valid_i  <= 1'b0;
    in_byte_i   <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, reset settings (lower case, full capacity): ASCII letters
    // at both ends of the range, the top ASCII code, accented capitals mapped
    // to small, a three-byte character passed through, a stray continuation
    // byte, a six-byte lead cut short by the terminator, and a held two-byte
    // lead that the terminator drops.
    seq = '{8'h41, 8'h5A, 8'h7F, 8'hC3, 8'h80, 8'hC4, 8'h80, 8'hE2, 8'h82, 8'hAC,
            8'h80, 8'hFF, 8'h00, 8'hC3, 8'h00};
    foreach (seq[i]) send_byte(seq[i]);

    // Upper case with room for two bytes plus the terminator: the third
    // letter is refused and the one after it is skipped.
    drain();
    configure(MODE_UPPER, 16'd3);
    seq = '{8'h61, 8'h7A, 8'h62, 8'h63, 8'h00};
    foreach (seq[i]) send_byte(seq[i]);

    // Accent stripping with little room: a table hit, a lead completed by a
    // byte that is not a continuation byte, then the room runs out.
    drain();
    configure(MODE_STRIP, 16'd2);
    seq = '{8'hC3, 8'hA9, 8'hC3, 8'h41, 8'h78, 8'h00};
    foreach (seq[i]) send_byte(seq[i]);

    // Mode code three behaves as accent stripping.
    drain();
    configure(MODE_STRIP_ALIAS, 16'hFFFF);
    seq = '{8'hC7, 8'h8D, 8'h00};
    foreach (seq[i]) send_byte(seq[i]);

    // Random part: each phase picks a mode and a capacity, biased towards small
    // capacities so that the room rules bite, then sends strings or noise.
    while (bytes_counted < ITEMS) begin
      drain();
      // The last stretch of the run goes at full speed on both sides.
      if (bytes_counted > ITEMS - 70) idle_on = 1'b0;
      mode_pick = 2'($urandom_range(0, 3));
      case ($urandom_range(0, 7))
        0:       cap_pick = 16'd0;
        1:       cap_pick = 16'hFFFF;
        2, 3:    cap_pick = 16'($urandom_range(1, 6));
        4, 5:    cap_pick = 16'($urandom_range(7, 40));
        default: cap_pick = 16'($urandom_range(41, 65534));
      endcase
      if (phase == HOLD_PHASE) begin
        mode_pick = MODE_LOWER;
        cap_pick  = 16'hFFFF;
      end
      configure(mode_pick, cap_pick);
      if (phase == HOLD_PHASE) begin
        long_hold = 1'b1;
        repeat (3) send_text(12, 1'b1);
      end else if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(5, 20))
          send_byte(($urandom_range(0, 9) == 0) ? 8'h00 : 8'($urandom_range(1, 255)));
      end else begin
        repeat ($urandom_range(1, 3)) send_text($urandom_range(2, 12), 1'b1);
      end
      if ($urandom_range(0, 5) == 0) send_text($urandom_range(1, 4), 1'b0);
      phase++;
    end

    drain();
    board.report_leftover();
    $display("Run covered %0d input bytes over %0d register settings and %0d phases.",
             bytes_counted, settings_used, phase);
    $display("%0d output beats checked, %0d strings closed, %0d mismatches.",
             board.beats_checked, board.strings_closed, board.mismatches);
    if (board.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
